// ===== hw/rtl/dasps_pkg.sv =====
// ============================================================================
// dasps_pkg
// Shared types and constants of the dual-axis step pulse scheduler.
// ============================================================================
package dasps_pkg;

    // Command codes carried in the kind field of an input word.
    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_SET_RATES = 3'd1,
        CMD_MOVE      = 3'd2,
        CMD_ENABLE    = 3'd3,
        CMD_DISABLE   = 3'd4,
        CMD_START     = 3'd5,
        CMD_STOP      = 3'd6
    } cmd_t;

    // Register map: register index i sits at byte address 4*i.
    localparam int CFG_ADDR_BITS = 4;

    typedef enum logic [1:0] {
        REG_ALT_ENABLE_INVERTED   = 2'd0,
        REG_ALT_POSITIVE_DIR_HIGH = 2'd1,
        REG_AZM_ENABLE_INVERTED   = 2'd2,
        REG_AZM_POSITIVE_DIR_HIGH = 2'd3
    } reg_idx_t;

    // Pin polarity settings of one axis.
    typedef struct packed {
        logic enable_inverted;
        logic positive_dir_high;
    } pol_t;

    // Per-axis status after a word has been processed.
    typedef struct packed {
        logic step;
        logic dir_positive;
        logic enabled;
        logic moving;
    } axis_flags_t;

endpackage

// ===== hw/rtl/dasps_cfg.sv =====
// ============================================================================
// dasps_cfg
// Register file for the pin polarity settings, written over a simple APB port.
// ============================================================================
module dasps_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dasps_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    output dasps_pkg::pol_t                      alt_pol,
    output dasps_pkg::pol_t                      azm_pol
);

    dasps_pkg::pol_t     alt_pol_reg;
    dasps_pkg::pol_t     alt_pol_next;
    dasps_pkg::pol_t     azm_pol_reg;
    dasps_pkg::pol_t     azm_pol_next;
    dasps_pkg::reg_idx_t reg_idx;
    logic                wr_en;
    logic                rd_bit;

    assign reg_idx = dasps_pkg::reg_idx_t'(paddr[dasps_pkg::CFG_ADDR_BITS-1:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        alt_pol_next = alt_pol_reg;
        azm_pol_next = azm_pol_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                dasps_pkg::REG_ALT_ENABLE_INVERTED:   alt_pol_next.enable_inverted = pwdata[0];
                dasps_pkg::REG_ALT_POSITIVE_DIR_HIGH: alt_pol_next.positive_dir_high = pwdata[0];
                dasps_pkg::REG_AZM_ENABLE_INVERTED:   azm_pol_next.enable_inverted = pwdata[0];
                dasps_pkg::REG_AZM_POSITIVE_DIR_HIGH: azm_pol_next.positive_dir_high = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            dasps_pkg::REG_ALT_ENABLE_INVERTED:   rd_bit = alt_pol_reg.enable_inverted;
            dasps_pkg::REG_ALT_POSITIVE_DIR_HIGH: rd_bit = alt_pol_reg.positive_dir_high;
            dasps_pkg::REG_AZM_ENABLE_INVERTED:   rd_bit = azm_pol_reg.enable_inverted;
            dasps_pkg::REG_AZM_POSITIVE_DIR_HIGH: rd_bit = azm_pol_reg.positive_dir_high;
            default:                              rd_bit = 1'b0;
        endcase
    end

    assign prdata = {31'd0, rd_bit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alt_pol_reg <= '{enable_inverted: 1'b0, positive_dir_high: 1'b1};
            azm_pol_reg <= '{enable_inverted: 1'b0, positive_dir_high: 1'b1};
        end
        else
        begin
            alt_pol_reg <= alt_pol_next;
            azm_pol_reg <= azm_pol_next;
        end
    end

    assign alt_pol = alt_pol_reg;
    assign azm_pol = azm_pol_reg;

endmodule

// ===== hw/rtl/dasps_axis.sv =====
// ============================================================================
// dasps_axis
// State and single-pass update logic of one stepper axis.
// ============================================================================
module dasps_axis
#(
    parameter int PERIOD_BITS   = 24,
    parameter int POSITION_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  dasps_pkg::cmd_t           cmd,
    input  logic                      running,
    input  logic [PERIOD_BITS-1:0]    rate_period,
    input  logic                      rate_positive,
    input  logic [POSITION_BITS-1:0]  target,
    output dasps_pkg::axis_flags_t    flags,
    output logic [POSITION_BITS-1:0]  position
);

    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [PERIOD_BITS-1:0]   per_reg;
    logic [PERIOD_BITS-1:0]   per_next;
    logic                     rpos_reg;
    logic                     rpos_next;
    logic [PERIOD_BITS-1:0]   cnt_reg;
    logic [PERIOD_BITS-1:0]   cnt_next;
    logic [POSITION_BITS-1:0] tgt_reg;
    logic [POSITION_BITS-1:0] tgt_next;
    logic                     tv_reg;
    logic                     tv_next;
    logic                     dir_reg;
    logic                     dir_next;
    logic                     en_reg;
    logic                     en_next;
    logic                     step;

    // Tick path: target check before the step, the step itself, and the check after it.
    logic                     hit_pre;
    logic [POSITION_BITS-1:0] pos_pre;
    logic [PERIOD_BITS-1:0]   per_pre;
    logic                     tv_pre;
    logic [POSITION_BITS-1:0] pos_stepped;
    logic                     hit_post;
    logic                     cnt_expired;
    // Move path.
    logic [PERIOD_BITS-1:0]   move_per;
    logic                     hit_move;

    // The target counts as reached when the position equals it, or when a moving
    // axis has already gone past it in its direction of travel.
    function automatic logic target_hit(
        input logic [POSITION_BITS-1:0] p,
        input logic [POSITION_BITS-1:0] t,
        input logic                     moving,
        input logic                     dir_pos
    );
        logic passed;
        passed = dir_pos ? ($signed(p) >= $signed(t)) : ($signed(p) <= $signed(t));
        return (p == t) || (moving && passed);
    endfunction

    always_comb
    begin
        hit_pre     = tv_reg && target_hit(pos_reg, tgt_reg, per_reg != '0, rpos_reg);
        pos_pre     = hit_pre ? tgt_reg : pos_reg;
        per_pre     = hit_pre ? '0 : per_reg;
        tv_pre      = tv_reg && !hit_pre;
        pos_stepped = rpos_reg ? pos_pre + POSITION_BITS'(1) : pos_pre - POSITION_BITS'(1);
        hit_post    = tv_pre && target_hit(pos_stepped, tgt_reg, per_pre != '0, rpos_reg);
        cnt_expired = (cnt_reg[PERIOD_BITS-1:1] == '0);
        move_per    = (target == pos_reg) ? '0 : rate_period;
        hit_move    = target_hit(pos_reg, target, move_per != '0, rate_positive);
    end

    always_comb
    begin
        pos_next  = pos_reg;
        per_next  = per_reg;
        rpos_next = rpos_reg;
        cnt_next  = cnt_reg;
        tgt_next  = tgt_reg;
        tv_next   = tv_reg;
        dir_next  = dir_reg;
        en_next   = en_reg;
        step      = 1'b0;
        case (cmd)
            dasps_pkg::CMD_TICK:
            begin
                if (running)
                begin
                    pos_next = pos_pre;
                    per_next = per_pre;
                    tv_next  = tv_pre;
                    if (per_pre != '0)
                    begin
                        if (cnt_expired)
                        begin
                            step     = 1'b1;
                            dir_next = rpos_reg;
                            en_next  = 1'b1;
                            cnt_next = per_pre;
                            pos_next = hit_post ? tgt_reg : pos_stepped;
                            per_next = hit_post ? '0 : per_pre;
                            tv_next  = tv_pre && !hit_post;
                        end
                        else
                        begin
                            cnt_next = cnt_reg - PERIOD_BITS'(1);
                        end
                    end
                end
            end
            dasps_pkg::CMD_SET_RATES:
            begin
                tv_next   = 1'b0;
                per_next  = rate_period;
                rpos_next = rate_positive;
                cnt_next  = rate_period;
            end
            dasps_pkg::CMD_MOVE:
            begin
                tgt_next  = target;
                rpos_next = rate_positive;
                if (hit_move)
                begin
                    pos_next = target;
                    per_next = '0;
                    tv_next  = 1'b0;
                    cnt_next = '0;
                end
                else
                begin
                    per_next = move_per;
                    tv_next  = 1'b1;
                    cnt_next = move_per;
                end
            end
            dasps_pkg::CMD_ENABLE:
            begin
                en_next = 1'b1;
            end
            dasps_pkg::CMD_DISABLE:
            begin
                per_next = '0;
                en_next  = 1'b0;
            end
            dasps_pkg::CMD_STOP:
            begin
                if (running)
                begin
                    per_next = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            per_reg  <= '0;
            rpos_reg <= 1'b0;
            cnt_reg  <= '0;
            tv_reg   <= 1'b0;
            dir_reg  <= 1'b0;
            en_reg   <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg  <= pos_next;
            per_reg  <= per_next;
            rpos_reg <= rpos_next;
            cnt_reg  <= cnt_next;
            tv_reg   <= tv_next;
            dir_reg  <= dir_next;
            en_reg   <= en_next;
        end
    end

    // The target is only ever read while its valid flag is set.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tgt_reg <= tgt_next;
        end
    end

    assign flags.step         = step;
    assign flags.dir_positive = dir_next;
    assign flags.enabled      = en_next;
    assign flags.moving       = (per_next != '0);
    assign position           = pos_next;

endmodule

// ===== hw/rtl/dual_axis_step_pulse_scheduler.sv =====
// ============================================================================
// dual_axis_step_pulse_scheduler
// Step and direction scheduler for an altitude and an azimuth stepper axis.
// ============================================================================
// Usage: each word on the slave stream is one command, its code in s_axis_tuser;
// the data holds the two step periods with their signs and the two move targets.
// A tick counts down every moving axis while the scheduler is running and emits
// a step when an axis count expires; the other commands set rates, start moves
// towards targets, enable or disable both axes, and start or stop the scheduler.
// For every accepted word exactly one status word leaves on the master stream:
// step flags, direction and enable pin levels, positions, moving flags and the
// running flag, all as they stand after the command.
// From acceptance a word passes through the input register, then the axis update and
// the result register, to m_axis_tvalid. A new word is taken in every cycle while the
// receiver keeps up; the axis state feeds back within the update stage alone. If the
// receiver stalls, the result register holds its word, the input register fills with
// the next word, and only then does s_axis_tready drop. Reset clears all axis state
// but the targets, stops the scheduler, empties both registers and returns the pin
// polarities to enable active high and direction high for positive. The user must
// write the APB registers only while the stream is idle; the block does not enforce it.
// ============================================================================
module dual_axis_step_pulse_scheduler
#(
    parameter int PERIOD_BITS   = 24,
    parameter int POSITION_BITS = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Slave stream.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [23:0] alt_period, [24] alt_positive, [48:25] azm_period, [49] azm_positive,
    // [81:50] alt_target, [113:82] azm_target, [119:114] zero
    input  logic [119:0]                         s_axis_tdata,
    // [2:0] cmd
    input  logic [2:0]                           s_axis_tuser,
    // Master stream.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] alt_step, [1] alt_dir_level, [2] alt_enable_level, [34:3] alt_position,
    // [35] alt_moving, [36] azm_step, [37] azm_dir_level, [38] azm_enable_level,
    // [70:39] azm_position, [71] azm_moving, [72] is_running, [79:73] zero
    output logic [79:0]                          m_axis_tdata,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dasps_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    // Input register.
    logic                     in_valid_reg;
    logic                     in_valid_next;
    logic [2:0]               in_cmd_reg;
    logic [113:0]             in_data_reg;
    // Result register.
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [79:0]              out_data_reg;
    logic [79:0]              out_data_next;
    // Scheduler run flag.
    logic                     running_reg;
    logic                     running_next;

    logic                     s_accept;
    logic                     out_free;
    logic                     advance;
    dasps_pkg::cmd_t          cmd;

    dasps_pkg::pol_t          alt_pol;
    dasps_pkg::pol_t          azm_pol;

    logic [31:0]              alt_per_wide;
    logic [31:0]              azm_per_wide;
    logic [63:0]              alt_tgt_wide;
    logic [63:0]              azm_tgt_wide;
    logic [63:0]              alt_pos_wide;
    logic [63:0]              azm_pos_wide;

    dasps_pkg::axis_flags_t   alt_flags;
    dasps_pkg::axis_flags_t   azm_flags;
    logic [POSITION_BITS-1:0] alt_position;
    logic [POSITION_BITS-1:0] azm_position;

    // The result register frees itself when its word is taken; the input register
    // moves on whenever the result register can take the next status word.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign cmd = dasps_pkg::cmd_t'(in_cmd_reg);

    always_comb
    begin
        running_next = running_reg;
        if (cmd == dasps_pkg::CMD_START)
        begin
            running_next = 1'b1;
        end
        else if (cmd == dasps_pkg::CMD_STOP)
        begin
            running_next = 1'b0;
        end
    end

    // Periods are cut or zero-extended to the counter width; targets are
    // sign-extended and then cut to the position width.
    assign alt_per_wide = {8'd0, in_data_reg[23:0]};
    assign azm_per_wide = {8'd0, in_data_reg[48:25]};
    assign alt_tgt_wide = {{32{in_data_reg[81]}}, in_data_reg[81:50]};
    assign azm_tgt_wide = {{32{in_data_reg[113]}}, in_data_reg[113:82]};

    dasps_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .alt_pol (alt_pol),
        .azm_pol (azm_pol)
    );

    dasps_axis
    #(
        .PERIOD_BITS   (PERIOD_BITS),
        .POSITION_BITS (POSITION_BITS)
    )
    u_alt
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .cmd           (cmd),
        .running       (running_reg),
        .rate_period   (alt_per_wide[PERIOD_BITS-1:0]),
        .rate_positive (in_data_reg[24]),
        .target        (alt_tgt_wide[POSITION_BITS-1:0]),
        .flags         (alt_flags),
        .position      (alt_position)
    );

    dasps_axis
    #(
        .PERIOD_BITS   (PERIOD_BITS),
        .POSITION_BITS (POSITION_BITS)
    )
    u_azm
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .cmd           (cmd),
        .running       (running_reg),
        .rate_period   (azm_per_wide[PERIOD_BITS-1:0]),
        .rate_positive (in_data_reg[49]),
        .target        (azm_tgt_wide[POSITION_BITS-1:0]),
        .flags         (azm_flags),
        .position      (azm_position)
    );

    // Positions leave as their low 32 bits, zero-extended when narrower.
    always_comb
    begin
        alt_pos_wide                      = '0;
        azm_pos_wide                      = '0;
        alt_pos_wide[POSITION_BITS-1:0]   = alt_position;
        azm_pos_wide[POSITION_BITS-1:0]   = azm_position;
    end

    // Pin levels apply the configured polarities to the logical state.
    always_comb
    begin
        out_data_next        = '0;
        out_data_next[0]     = alt_flags.step;
        out_data_next[1]     = (alt_flags.dir_positive == alt_pol.positive_dir_high);
        out_data_next[2]     = alt_flags.enabled ^ alt_pol.enable_inverted;
        out_data_next[34:3]  = alt_pos_wide[31:0];
        out_data_next[35]    = alt_flags.moving;
        out_data_next[36]    = azm_flags.step;
        out_data_next[37]    = (azm_flags.dir_positive == azm_pol.positive_dir_high);
        out_data_next[38]    = azm_flags.enabled ^ azm_pol.enable_inverted;
        out_data_next[70:39] = azm_pos_wide[31:0];
        out_data_next[71]    = azm_flags.moving;
        out_data_next[72]    = running_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            running_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                running_reg <= running_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_data_reg <= s_axis_tdata[113:0];
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== dv/dual_axis_step_pulse_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dual_axis_step_pulse_scheduler_tb
// Self-checking testbench of the dual-axis step pulse scheduler. Command words
// enter on the slave stream with random gaps, status words leave on the master
// stream under random back-pressure, and every status word is compared field by
// field with a word typed in for some directed rows, else predicted by the testbench's own model of both axes.
// A short directed table comes first, then random motion bursts and noise under
// several pin polarity settings written over the APB port.
// ============================================================================
module dual_axis_step_pulse_scheduler_tb;

    import dasps_pkg::*;

    localparam int          PHASES        = 6;
    localparam int          PHASE_WORDS   = 65;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int          REPORT_LIMIT  = 10;
    // Code 7 is not a command; the block takes the word and changes nothing.
    localparam logic [2:0]  CMD_UNUSED    = 3'd7;

    // Slave data layout, first field in the lowest bits.
    typedef struct packed {
        logic [5:0]  pad;
        logic [31:0] azm_target;
        logic [31:0] alt_target;
        logic        azm_positive;
        logic [23:0] azm_period;
        logic        alt_positive;
        logic [23:0] alt_period;
    } cmd_word_t;

    typedef struct packed {
        logic [2:0] op;
        cmd_word_t  word;
    } item_t;

    // Master data layout, first field in the lowest bits.
    typedef struct packed {
        logic [6:0]  pad;
        logic        running;
        logic        azm_moving;
        logic [31:0] azm_position;
        logic        azm_enable;
        logic        azm_dir;
        logic        azm_step;
        logic        alt_moving;
        logic [31:0] alt_position;
        logic        alt_enable;
        logic        alt_dir;
        logic        alt_step;
    } status_t;

    typedef struct packed {
        item_t   stim;
        logic    typed;
        status_t want;
    } dir_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [119:0]             s_axis_tdata;
    logic [2:0]               s_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [79:0]              m_axis_tdata;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    dual_axis_step_pulse_scheduler i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------------
    // Model of both axes. Index 0 is altitude, index 1 is azimuth.
    // ------------------------------------------------------------------------
    logic [31:0] ax_pos       [2];
    logic [23:0] ax_period    [2];
    logic [23:0] ax_count     [2];
    logic        ax_rate_pos  [2];
    logic [31:0] ax_tgt       [2];
    logic        ax_tgt_valid [2];
    logic        ax_dir_pos   [2];
    logic        ax_en        [2];
    logic        sched_running;
    logic        pol_en_low   [2];
    logic        pol_dir_high [2];

    status_t     pending_status [$];
    dir_row_t    dir_rows [$];
    int          mismatches   = 0;
    int          status_count = 0;
    int unsigned cycle_count  = 0;

    // An axis that has reached its target, or lies beyond it in the direction
    // of travel, lands exactly on the target and stops there.
    function automatic void settle_axis(int a);
        logic hit;
        if (ax_tgt_valid[a])
        begin
            hit = (ax_pos[a] == ax_tgt[a]);
            if (ax_period[a] != '0)
            begin
                if (ax_rate_pos[a] && $signed(ax_pos[a]) >= $signed(ax_tgt[a]))
                    hit = 1'b1;
                if (!ax_rate_pos[a] && $signed(ax_pos[a]) <= $signed(ax_tgt[a]))
                    hit = 1'b1;
            end
            if (hit)
            begin
                ax_pos[a]       = ax_tgt[a];
                ax_period[a]    = '0;
                ax_tgt_valid[a] = 1'b0;
            end
        end
    endfunction

    function automatic logic advance_axis(int a);
        logic stepped;
        stepped = 1'b0;
        settle_axis(a);
        if (ax_period[a] != '0)
        begin
            if (ax_count[a] <= 24'd1)
            begin
                ax_dir_pos[a] = ax_rate_pos[a];
                ax_en[a]      = 1'b1;
                ax_pos[a]     = ax_rate_pos[a] ? ax_pos[a] + 32'd1 : ax_pos[a] - 32'd1;
                stepped       = 1'b1;
                ax_count[a]   = ax_period[a];
                settle_axis(a);
            end
            else
            begin
                ax_count[a] = ax_count[a] - 24'd1;
            end
        end
        return stepped;
    endfunction

    // Applies one command word and returns the status word it should produce.
    function automatic status_t scheduler_step(item_t it);
        status_t     s;
        logic [23:0] per     [2];
        logic        sgn     [2];
        logic [31:0] tgt     [2];
        logic        stepped [2];
        per[0] = it.word.alt_period;
        per[1] = it.word.azm_period;
        sgn[0] = it.word.alt_positive;
        sgn[1] = it.word.azm_positive;
        tgt[0] = it.word.alt_target;
        tgt[1] = it.word.azm_target;
        for (int a = 0; a < 2; a++)
        begin
            stepped[a] = 1'b0;
            case (it.op)
                CMD_TICK:
                    if (sched_running)
                        stepped[a] = advance_axis(a);
                CMD_SET_RATES:
                begin
                    ax_tgt_valid[a] = 1'b0;
                    ax_period[a]    = per[a];
                    ax_rate_pos[a]  = sgn[a];
                    ax_count[a]     = per[a];
                end
                CMD_MOVE:
                begin
                    ax_tgt[a]       = tgt[a];
                    ax_tgt_valid[a] = 1'b1;
                    ax_rate_pos[a]  = sgn[a];
                    ax_period[a]    = (tgt[a] == ax_pos[a]) ? '0 : per[a];
                    settle_axis(a);
                    ax_count[a]     = ax_period[a];
                end
                CMD_ENABLE:
                    ax_en[a] = 1'b1;
                CMD_DISABLE:
                begin
                    ax_period[a] = '0;
                    ax_en[a]     = 1'b0;
                end
                CMD_STOP:
                    if (sched_running)
                        ax_period[a] = '0;
                default:
                    ;
            endcase
        end
        if (it.op == CMD_START)
            sched_running = 1'b1;
        else if (it.op == CMD_STOP)
            sched_running = 1'b0;

        s              = '0;
        s.alt_step     = stepped[0];
        s.alt_dir      = (ax_dir_pos[0] == pol_dir_high[0]);
        s.alt_enable   = ax_en[0] ^ pol_en_low[0];
        s.alt_position = ax_pos[0];
        s.alt_moving   = |ax_period[0];
        s.azm_step     = stepped[1];
        s.azm_dir      = (ax_dir_pos[1] == pol_dir_high[1]);
        s.azm_enable   = ax_en[1] ^ pol_en_low[1];
        s.azm_position = ax_pos[1];
        s.azm_moving   = |ax_period[1];
        s.running      = sched_running;
        return s;
    endfunction

    // Words that the block takes without any effect on its state.
    function automatic logic is_noop(item_t it);
        return (it.op == CMD_TICK && !sched_running) ||
               (it.op == CMD_START && sched_running) ||
               (it.op == CMD_STOP && !sched_running) ||
               (it.op == CMD_UNUSED);
    endfunction

    // Status just after reset with the reset polarities: nothing moves, all
    // pins low unless the axes have been enabled.
    function automatic status_t idle_status(logic run, logic en);
        status_t s;
        s            = '0;
        s.running    = run;
        s.alt_enable = en;
        s.azm_enable = en;
        return s;
    endfunction

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Short periods keep the axes stepping; a few full-range ones cover every bit.
    function automatic logic [23:0] random_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 75)
            return 24'($urandom_range(1, 4));
        else if (r < 88)
            return 24'($urandom_range(5, 30));
        else if (r < 95)
            return 24'($urandom);
        return 24'hFF_FFFF;
    endfunction

    // Targets mostly lie a few steps either side of the current position.
    function automatic logic [31:0] random_target(int a);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return ax_pos[a] + 32'($urandom_range(0, 40)) - 32'd20;
        else if (r < 85)
            return 32'($urandom);
        else if (r < 92)
            return 32'h7FFF_FFFF;
        return 32'h8000_0000;
    endfunction

    function automatic item_t make_random_item();
        item_t it;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 45)
            it.op = CMD_TICK;
        else if (r < 57)
            it.op = CMD_SET_RATES;
        else if (r < 72)
            it.op = CMD_MOVE;
        else if (r < 78)
            it.op = CMD_ENABLE;
        else if (r < 82)
            it.op = CMD_DISABLE;
        else if (r < 91)
            it.op = CMD_START;
        else if (r < 98)
            it.op = CMD_STOP;
        else
            it.op = CMD_UNUSED;
        it.word              = '0;
        it.word.alt_period   = random_period();
        it.word.alt_positive = 1'($urandom_range(0, 1));
        it.word.azm_period   = random_period();
        it.word.azm_positive = 1'($urandom_range(0, 1));
        it.word.alt_target   = random_target(0);
        it.word.azm_target   = random_target(1);
        return it;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("status word %0d: %s expected %h, got %h",
                         status_count, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Clock, cycle counter and watchdog.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("dual_axis_step_pulse_scheduler_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, changed on the falling edge.
    // ------------------------------------------------------------------------
    initial
    begin : ready_gen
        int gap;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            repeat ($urandom_range(0, 8)) @(negedge clk);
        end
    end

    // Every status word taken on a rising edge is checked against the oldest
    // prediction still waiting.
    always @(posedge clk)
    begin : result_check
        status_t got;
        status_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("status word %0d arrived with none expected: %h",
                             status_count, m_axis_tdata);
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("alt_step",         32'(want.alt_step),     32'(got.alt_step));
                check_field("alt_dir_level",    32'(want.alt_dir),      32'(got.alt_dir));
                check_field("alt_enable_level", 32'(want.alt_enable),   32'(got.alt_enable));
                check_field("alt_position",     want.alt_position,      got.alt_position);
                check_field("alt_moving",       32'(want.alt_moving),   32'(got.alt_moving));
                check_field("azm_step",         32'(want.azm_step),     32'(got.azm_step));
                check_field("azm_dir_level",    32'(want.azm_dir),      32'(got.azm_dir));
                check_field("azm_enable_level", 32'(want.azm_enable),   32'(got.azm_enable));
                check_field("azm_position",     want.azm_position,      got.azm_position);
                check_field("azm_moving",       32'(want.azm_moving),   32'(got.azm_moving));
                check_field("is_running",       32'(want.running),      32'(got.running));
                check_field("padding",          32'(want.pad),          32'(got.pad));
            end
            status_count++;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side. Every task is entered on a falling edge and leaves on one,
    // so that the inputs only ever change on a falling edge, away from the rising edges where they are sampled.
    // ------------------------------------------------------------------------

    // Offers one word after a random gap, waits for it to be taken and queues
    // the expected status: the typed-in one where given, else the model's.
    // The model runs in either case so that its state follows the block.
    task automatic send_word(item_t it, logic typed, status_t want, inout int counted);
        int      gap;
        status_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = it.word;
        s_axis_tuser  = it.op;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (!is_noop(it))
            counted++;
        predicted = scheduler_step(it);
        pending_status.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Every word yields a status word, so once none is waiting the block holds
    // nothing; the extra cycles cover its two-stage pipeline with margin.
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value on the
    // rising edge where the access phase meets pready.
    task automatic write_reg(reg_idx_t idx, logic val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {31'd0, val};
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_ALT_ENABLE_INVERTED:   pol_en_low[0]   = val;
            REG_ALT_POSITIVE_DIR_HIGH: pol_dir_high[0] = val;
            REG_AZM_ENABLE_INVERTED:   pol_en_low[1]   = val;
            REG_AZM_POSITIVE_DIR_HIGH: pol_dir_high[1] = val;
            default: ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // A well-formed stretch of motion: sometimes an enable, a rate or a move, the scheduler running,
    // and a run of ticks, with random content in every field.
    task automatic motion_burst(inout int counted);
        item_t it;
        if ($urandom_range(0, 4) == 0)
        begin
            it    = make_random_item();
            it.op = CMD_ENABLE;
            send_word(it, 1'b0, '0, counted);
        end
        it    = make_random_item();
        it.op = ($urandom_range(0, 2) == 0) ? CMD_SET_RATES : CMD_MOVE;
        send_word(it, 1'b0, '0, counted);
        if (!sched_running)
        begin
            it    = make_random_item();
            it.op = CMD_START;
            send_word(it, 1'b0, '0, counted);
        end
        repeat ($urandom_range(4, 24))
        begin
            it    = make_random_item();
            it.op = CMD_TICK;
            send_word(it, 1'b0, '0, counted);
        end
    endtask

    task automatic add_row(logic [2:0] op, logic [23:0] alt_per, logic alt_sgn,
                           logic [23:0] azm_per, logic azm_sgn, logic [31:0] alt_tgt,
                           logic [31:0] azm_tgt, logic typed, status_t want);
        dir_row_t row;
        row.stim.op                = op;
        row.stim.word              = '0;
        row.stim.word.alt_period   = alt_per;
        row.stim.word.alt_positive = alt_sgn;
        row.stim.word.azm_period   = azm_per;
        row.stim.word.azm_positive = azm_sgn;
        row.stim.word.alt_target   = alt_tgt;
        row.stim.word.azm_target   = azm_tgt;
        row.typed                  = typed;
        row.want                   = want;
        dir_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        int       counted;
        int       dummy;
        logic [3:0] setting;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        dummy         = 0;
        for (int a = 0; a < 2; a++)
        begin
            ax_pos[a]       = '0;
            ax_period[a]    = '0;
            ax_count[a]     = '0;
            ax_rate_pos[a]  = 1'b0;
            ax_tgt[a]       = '0;
            ax_tgt_valid[a] = 1'b0;
            ax_dir_pos[a]   = 1'b0;
            ax_en[a]        = 1'b0;
            pol_en_low[a]   = 1'b0;
            pol_dir_high[a] = 1'b1;
        end
        sched_running = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table, run with the reset polarities. Rows whose status is
        // plain from reset carry it typed in; the rest rely on the model.
        // Commands with no effect while stopped, and the unused code.
        add_row(CMD_TICK,   24'd5, 1'b1, 24'd5, 1'b1, 32'd3, 32'd3, 1'b1,
                idle_status(1'b0, 1'b0));
        add_row(CMD_UNUSED, 24'd1, 1'b1, 24'd1, 1'b0, 32'd0, 32'd0, 1'b1,
                idle_status(1'b0, 1'b0));
        add_row(CMD_STOP,   24'd0, 1'b0, 24'd0, 1'b0, 32'd0, 32'd0, 1'b1,
                idle_status(1'b0, 1'b0));
        add_row(CMD_START,  24'd0, 1'b0, 24'd0, 1'b0, 32'd0, 32'd0, 1'b1,
                idle_status(1'b1, 1'b0));
        add_row(CMD_ENABLE, 24'd0, 1'b0, 24'd0, 1'b0, 32'd0, 32'd0, 1'b1,
                idle_status(1'b1, 1'b1));
        // Shortest and longest periods; a second start is ignored.
        add_row(CMD_SET_RATES, 24'd1, 1'b1, 24'hFF_FFFF, 1'b0, 32'd0, 32'd0, 1'b0, '0);
        add_row(CMD_START,  24'd0, 1'b0, 24'd0, 1'b0, 32'd0, 32'd0, 1'b0, '0);
        add_row(CMD_TICK,   24'd0, 1'b0, 24'd0, 1'b0, 32'd0, 32'd0, 1'b0, '0);
        add_row(CMD_TICK,   24'd0, 1'b0, 24'd0, 1'b0, 32'd0, 32'd0, 1'b0, '0);
        // Moves in both directions that end on their targets.
        add_row(CMD_MOVE,   24'd2, 1'b1, 24'd1, 1'b0, 32'd5, -32'sd3, 1'b0, '0);
        repeat (6)
            add_row(CMD_TICK, 24'd0, 1'b0, 24'd0, 1'b0, 32'd0, 32'd0, 1'b0, '0);
        // Target behind the direction of travel, and target already reached.
        add_row(CMD_MOVE,   24'd3, 1'b1, 24'd2, 1'b0, -32'sd10, -32'sd3, 1'b0, '0);
        // Extreme targets, both behind, so both axes snap to them.
        add_row(CMD_MOVE,   24'd1, 1'b1, 24'd1, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF,
                1'b0, '0);
        // Stepping past the ends of the position range wraps round.
        add_row(CMD_SET_RATES, 24'd1, 1'b0, 24'd1, 1'b1, 32'd0, 32'd0, 1'b0, '0);
        add_row(CMD_TICK,   24'd0, 1'b0, 24'd0, 1'b0, 32'd0, 32'd0, 1'b0, '0);
        add_row(CMD_TICK,   24'd0, 1'b0, 24'd0, 1'b0, 32'd0, 32'd0, 1'b0, '0);
        // Stop while running, disable, and a tick with nothing running.
        add_row(CMD_STOP,   24'd0, 1'b0, 24'd0, 1'b0, 32'd0, 32'd0, 1'b0, '0);
        add_row(CMD_DISABLE, 24'd0, 1'b0, 24'd0, 1'b0, 32'd0, 32'd0, 1'b0, '0);
        add_row(CMD_TICK,   24'd0, 1'b0, 24'd0, 1'b0, 32'd0, 32'd0, 1'b0, '0);
        // Every field at its all-ones value.
        add_row(CMD_MOVE,   24'hFF_FFFF, 1'b1, 24'hFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 1'b0, '0);

        foreach (dir_rows[i])
            send_word(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want, dummy);
        wait_drained();

        // Random phases, each under its own pin polarity setting. Bit i of the
        // setting goes to register i; all clear and all set are the extremes.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       setting = 4'b0000;
                1:       setting = 4'b1111;
                2:       setting = 4'b0101;
                3:       setting = 4'b1010;
                default: setting = 4'($urandom);
            endcase
            write_reg(REG_ALT_ENABLE_INVERTED,   setting[0]);
            write_reg(REG_ALT_POSITIVE_DIR_HIGH, setting[1]);
            write_reg(REG_AZM_ENABLE_INVERTED,   setting[2]);
            write_reg(REG_AZM_POSITIVE_DIR_HIGH, setting[3]);

            counted = 0;
            while (counted < PHASE_WORDS)
            begin
                if ($urandom_range(0, 3) != 0)
                    motion_burst(counted);
                else
                    send_word(make_random_item(), 1'b0, '0, counted);
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("dual_axis_step_pulse_scheduler_tb: PASS");
        else
            $display("dual_axis_step_pulse_scheduler_tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/dasps_pkg.sv
hw/rtl/dasps_cfg.sv
hw/rtl/dasps_axis.sv
hw/rtl/dual_axis_step_pulse_scheduler.sv
dv/dual_axis_step_pulse_scheduler_tb.sv
